// ===== design/ght_pkg.sv =====
`default_nettype none
package ght_pkg;

	localparam int SLOTS = 128;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam logic [14:0] SEQ_RESET = 15'h2000;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_DUP      = 3'd1,
		ST_FULL     = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_ZEROHOST = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] host_id;
		logic [31:0] session_id;
		logic [31:0] handle;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [30:0] handle_out;
		logic [15:0] slot_out;
	} rsp_t;

	typedef struct packed {
		logic [31:0] host;
		logic [31:0] session;
		logic [30:0] handle;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic             vset;
		logic             vclr;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} store_wr_t;

endpackage
`default_nettype wire

// ===== design/ght_store.sv =====
`default_nettype none
module ght_store (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire [ght_pkg::IDX_W-1:0] rd_addr,
	input  ght_pkg::store_wr_t     wr,
	output ght_pkg::entry_t        rd_entry,
	output logic                   rd_valid
);
	import ght_pkg::*;

	entry_t            mem_q [SLOTS];
	logic [SLOTS-1:0]  valid_q;
	entry_t            rd_entry_s1;
	logic              rd_valid_s1;

	// entry storage, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
		rd_entry_s1 <= mem_q[rd_addr];
		rd_valid_s1 <= valid_q[rd_addr];
	end

	// occupancy bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.vset) begin
			valid_q[wr.addr] <= 1'b1;
		end else if (wr.vclr) begin
			valid_q[wr.addr] <= 1'b0;
		end
	end

	assign rd_entry = rd_entry_s1;
	assign rd_valid = rd_valid_s1;

endmodule
`default_nettype wire

// ===== design/ght_seq.sv =====
`default_nettype none
module ght_seq (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      req_valid,
	input  ght_pkg::req_t            req,
	output logic                     req_stall,
	output logic [ght_pkg::IDX_W-1:0] rd_addr,
	input  ght_pkg::entry_t          rd_entry,
	input  wire                      rd_valid,
	output ght_pkg::store_wr_t       wr,
	output logic                     res_valid,
	output ght_pkg::rsp_t            res,
	input  wire                      res_ready
);
	import ght_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SCAN   = 6'b000010,
		S_DRAIN  = 6'b000100,
		S_FINISH = 6'b001000,
		S_CHECK  = 6'b010000,
		S_RESP   = 6'b100000
	} state_t;

	state_t           state_q;
	logic [14:0]      seq_q;
	logic [IDX_W-1:0] cnt_q;
	logic             scan_vld_s1;
	logic             dup_q;
	logic             free_q;

	logic [1:0]       cmd_q;
	logic [31:0]      host_q;
	logic [31:0]      sess_q;
	logic [31:0]      hdl_q;
	logic [IDX_W-1:0] addr_s1;
	logic [IDX_W-1:0] free_idx_q;
	rsp_t             res_q;

	logic             accept;
	logic             in_range;
	logic             match;
	logic             add_ok;
	logic [30:0]      new_handle;

	assign accept     = req_valid && !req_stall;
	assign req_stall  = (state_q != S_IDLE);
	assign in_range   = {1'b0, req.handle[15:0]} < 17'(SLOTS);
	assign match      = rd_valid && !hdl_q[31] && (rd_entry.handle == hdl_q[30:0]);
	assign add_ok     = !dup_q && free_q;
	assign new_handle = {seq_q, 16'(free_idx_q)};

	always_comb begin
		rd_addr = cnt_q;
		if (state_q == S_IDLE) begin
			rd_addr = req.handle[IDX_W-1:0];
		end
	end

	always_comb begin
		wr = '0;
		if (state_q == S_FINISH && add_ok) begin
			wr.we   = 1'b1;
			wr.vset = 1'b1;
			wr.addr = free_idx_q;
			wr.data = '{host: host_q, session: sess_q, handle: new_handle};
		end else if (state_q == S_CHECK && match && cmd_q == CMD_DELETE) begin
			wr.vclr = 1'b1;
			wr.addr = hdl_q[IDX_W-1:0];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seq_q       <= SEQ_RESET;
			cnt_q       <= '0;
			scan_vld_s1 <= 1'b0;
			dup_q       <= 1'b0;
			free_q      <= 1'b0;
		end else begin
			if (scan_vld_s1) begin
				if (!rd_valid) begin
					free_q <= 1'b1;
				end else if (rd_entry.host == host_q && rd_entry.session == sess_q) begin
					dup_q <= 1'b1;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q       <= '0;
						scan_vld_s1 <= 1'b0;
						dup_q       <= 1'b0;
						free_q      <= 1'b0;
						priority if (req.cmd == CMD_ADD && req.host_id != '0) begin
							state_q <= S_SCAN;
						end else if ((req.cmd == CMD_LOOKUP || req.cmd == CMD_DELETE)
							&& in_range) begin
							state_q <= S_CHECK;
						end else begin
							state_q <= S_RESP;
						end
					end
				end
				S_SCAN: begin
					scan_vld_s1 <= 1'b1;
					cnt_q       <= cnt_q + 1'b1;
					if (cnt_q == IDX_W'(SLOTS - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					scan_vld_s1 <= 1'b0;
					state_q     <= S_FINISH;
				end
				S_FINISH: begin
					if (add_ok) begin
						seq_q <= seq_q + 1'b1;
					end
					state_q <= S_RESP;
				end
				S_CHECK: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item payload and result
	always_ff @(posedge clk) begin
		addr_s1 <= cnt_q;
		if (scan_vld_s1 && !rd_valid) begin
			free_idx_q <= addr_s1;
		end
		if (accept) begin
			cmd_q  <= req.cmd;
			host_q <= req.host_id;
			sess_q <= req.session_id;
			hdl_q  <= req.handle;
			if (req.cmd == CMD_ADD && req.host_id == '0) begin
				res_q <= '{status: ST_ZEROHOST, handle_out: '0, slot_out: '0};
			end else begin
				res_q <= '{status: ST_NOTFOUND, handle_out: '0, slot_out: '0};
			end
		end
		if (state_q == S_FINISH) begin
			priority if (dup_q) begin
				res_q <= '{status: ST_DUP, handle_out: '0, slot_out: '0};
			end else if (!free_q) begin
				res_q <= '{status: ST_FULL, handle_out: '0, slot_out: '0};
			end else begin
				res_q <= '{status: ST_OK, handle_out: new_handle,
					slot_out: 16'(free_idx_q)};
			end
		end
		if (state_q == S_CHECK) begin
			if (match) begin
				res_q <= '{status: ST_OK, handle_out: hdl_q[30:0],
					slot_out: 16'(hdl_q[IDX_W-1:0])};
			end else begin
				res_q <= '{status: ST_NOTFOUND, handle_out: '0, slot_out: '0};
			end
		end
	end

	assign res_valid = (state_q == S_RESP);
	assign res       = res_q;

endmodule
`default_nettype wire

// ===== design/generational_handle_table.sv =====
// generational handle table: a fixed table of SLOTS session slots
// request channel (req_valid / req_stall / req): one command per transfer,
//   add (host, session), look up handle, or delete handle
// response channel (rsp_valid / rsp_stall / rsp): exactly one transfer per
//   request, carrying status, handle and slot
// one command is worked at a time; req_stall is high while it is in flight
// add walks every slot through the entry memory, one read per cycle, then
//   passes the drain and finish states before it answers
// look up and delete read only the one addressed slot
// malformed commands (zero host, bad range, unused code) go straight to response
// the next request can be taken from the cycle after the previous result moves
//   into the response register, even while that register is still stalled
// rsp_stall holds the response register; a second result waits in the
//   sequencer, and requests stall behind it
// reset frees every slot at once (occupancy flops) and sets the
//   generation sequence to 0x2000; entry contents stay undefined
`default_nettype none
module generational_handle_table (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             req_valid,
	output logic            req_stall,
	input  ght_pkg::req_t   req,
	output logic            rsp_valid,
	input  wire             rsp_stall,
	output ght_pkg::rsp_t   rsp
);
	import ght_pkg::*;

	logic [IDX_W-1:0] rd_addr;
	entry_t           rd_entry;
	logic             rd_valid;
	store_wr_t        wr;
	logic             res_valid;
	rsp_t             res;
	logic             res_ready;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	// slot memory plus occupancy bits
	ght_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (rd_addr),
		.wr       (wr),
		.rd_entry (rd_entry),
		.rd_valid (rd_valid)
	);

	// command sequencer: scan, check, read-modify-write
	ght_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.rd_addr   (rd_addr),
		.rd_entry  (rd_entry),
		.rd_valid  (rd_valid),
		.wr        (wr),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	// response register: free when empty or when its transfer completes
	assign res_ready = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// payload only moves when the register is free
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire
